>>> hdl/sik_pkg.sv
// Shared types and constants for the swerve inverse kinematics block.
// No dependencies; imported by sik_wheel and swerve_inverse_kinematics.
`default_nettype none

package sik_pkg;

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0] NINETY_LO   = 16'sd12797;
  localparam logic signed [15:0] NINETY_HI   = 16'sd12939;
  localparam logic signed [15:0] FOLD_LIMIT  = 16'sd12944;

  localparam logic [1:0] REG_MAX_RPM     = 2'd0;
  localparam logic [1:0] REG_SPEED_SCALE = 2'd1;
  localparam logic [1:0] REG_HALF_TRACK  = 2'd2;

  typedef struct packed {
    logic signed [37:0] p;
    logic signed [37:0] q;
  } sik_vec_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] speed;
  } sik_res_t;

  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sik_wheel.sv
// Per-wheel speed and steering angle from one (p, q) vector, one wheel at a time.
// Serial CORDIC, bit-serial squaring and square root; depends on sik_pkg.
`default_nettype none

module sik_wheel
  import sik_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  sik_vec_t    vec,
  input  logic [14:0] max_rpm,
  output logic        done,
  output sik_res_t    res
);

  typedef enum logic [5:0] {
    W_IDLE = 6'b000001,
    W_NORM = 6'b000010,
    W_CORD = 6'b000100,
    W_SQ   = 6'b001000,
    W_SQRT = 6'b010000,
    W_FIN  = 6'b100000
  } wst_t;

  wst_t               state_r;
  logic               p_neg_r, q_neg_r, zero_r, huge_r;
  logic [36:0]        ap_r, aq_r, ax_r, ay_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [26:0] z_r;
  logic [4:0]         cnt_r;
  logic [27:0]        mp_r, mq_r;
  logic [56:0]        acc_r, r_r, bit_r;
  logic signed [15:0] held_r;
  logic               done_r;
  sik_res_t           res_r;

  logic [37:0]        ap_c, aq_c;
  logic [36:0]        m_c;
  logic signed [33:0] sx_c, sy_c;
  logic signed [26:0] tab_c;
  logic [56:0]        trial_c;
  logic [26:0]        zc_c;
  logic [26:0]        zr_c;
  logic [13:0]        fa_c;
  logic signed [15:0] raw_c, th_c, ath_c, fold_c;
  logic               neg_c;
  logic [29:0]        rnd_c;
  logic [14:0]        smag_c;
  logic [55:0]        sqp_c, sqq_c;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    ap_c    = vec.p[37] ? 38'(-vec.p) : vec.p;
    aq_c    = vec.q[37] ? 38'(-vec.q) : vec.q;
    m_c     = (ax_r > ay_r) ? ax_r : ay_r;
    sx_c    = cx_r >>> cnt_r;
    sy_c    = cy_r >>> cnt_r;
    tab_c   = $signed({3'b000, atan_entry(cnt_r)});
    trial_c = r_r + bit_r;
    sqp_c   = mp_r[27] ? {28'd0, ap_r[27:0]} : 56'd0;
    sqq_c   = mq_r[27] ? {28'd0, aq_r[27:0]} : 56'd0;

    zc_c = z_r[26] ? 27'd0 : 27'(z_r);
    zr_c = (zc_c + 27'd1024) >> 11;
    if (aq_r == 37'd0) begin
      fa_c = 14'd0;
    end else if (ap_r == 37'd0) begin
      fa_c = 14'(HALF_PI_Q13);
    end else if (zr_c > 27'(HALF_PI_Q13)) begin
      fa_c = 14'(HALF_PI_Q13);
    end else begin
      fa_c = zr_c[13:0];
    end

    raw_c = $signed({2'b00, fa_c});
    if (p_neg_r) raw_c = PI_Q13 - raw_c;
    if (q_neg_r) raw_c = -raw_c;
    if (zero_r) raw_c = 16'sd0;

    neg_c = (raw_c >= NINETY_LO && raw_c <= NINETY_HI) || p_neg_r;
    th_c  = zero_r ? held_r : raw_c;
    ath_c = th_c[15] ? -th_c : th_c;
    if (ath_c >= NINETY_LO && ath_c <= NINETY_HI) begin
      fold_c = -HALF_PI_Q13;
    end else if (ath_c >= FOLD_LIMIT) begin
      fold_c = th_c[15] ? th_c + PI_Q13 : th_c - PI_Q13;
    end else begin
      fold_c = th_c;
    end

    rnd_c = {1'b0, r_r[28:0]} + 30'd2048;
    if (huge_r || rnd_c[29:12] > {3'b000, max_rpm}) begin
      smag_c = max_rpm;
    end else begin
      smag_c = rnd_c[26:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      held_r  <= 16'sd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        W_IDLE: begin
          if (start) begin
            p_neg_r <= vec.p[37];
            q_neg_r <= vec.q[37];
            ap_r    <= ap_c[36:0];
            aq_r    <= aq_c[36:0];
            ax_r    <= ap_c[36:0];
            ay_r    <= aq_c[36:0];
            zero_r  <= (ap_c == 38'd0) && (aq_c == 38'd0);
            huge_r  <= (ap_c[36:28] != 9'd0) || (aq_c[36:28] != 9'd0);
            mp_r    <= ap_c[27:0];
            mq_r    <= aq_c[27:0];
            acc_r   <= 57'd0;
            cnt_r   <= 5'd0;
            if (ap_c == 38'd0 || aq_c == 38'd0) begin
              state_r <= ((ap_c[36:28] != 9'd0) || (aq_c[36:28] != 9'd0)) ? W_FIN : W_SQ;
            end else begin
              state_r <= W_NORM;
            end
          end
        end
        W_NORM: begin
          if (m_c[36:30] != 7'd0) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else if (!m_c[29]) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end else begin
            cx_r    <= $signed({4'b0000, ax_r[29:0]});
            cy_r    <= $signed({4'b0000, ay_r[29:0]});
            z_r     <= 27'sd0;
            cnt_r   <= 5'd0;
            state_r <= W_CORD;
          end
        end
        W_CORD: begin
          if (!cy_r[33]) begin
            cx_r <= cx_r + sy_c;
            cy_r <= cy_r - sx_c;
            z_r  <= z_r + tab_c;
          end else begin
            cx_r <= cx_r - sy_c;
            cy_r <= cy_r + sx_c;
            z_r  <= z_r - tab_c;
          end
          if (cnt_r == 5'd23) begin
            cnt_r   <= 5'd0;
            state_r <= huge_r ? W_FIN : W_SQ;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        W_SQ: begin
          acc_r <= {acc_r[55:0], 1'b0} + {1'b0, sqp_c} + {1'b0, sqq_c};
          mp_r  <= {mp_r[26:0], 1'b0};
          mq_r  <= {mq_r[26:0], 1'b0};
          if (cnt_r == 5'd27) begin
            cnt_r   <= 5'd0;
            r_r     <= 57'd0;
            bit_r   <= {1'b1, 56'd0};
            state_r <= W_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        W_SQRT: begin
          if (acc_r >= trial_c) begin
            acc_r <= acc_r - trial_c;
            r_r   <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (cnt_r == 5'd28) begin
            state_r <= W_FIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        W_FIN: begin
          if (!zero_r) held_r <= raw_c;
          res_r.angle <= fold_c;
          res_r.speed <= neg_c ? -$signed({1'b0, smag_c}) : $signed({1'b0, smag_c});
          done_r      <= 1'b1;
          state_r     <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == W_IDLE)) else $error("wheel start while busy");

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == W_FIN)) else $error("wheel done without finish");

  a_sqrt_from_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == W_SQRT) |-> !huge_r) else $error("square root on saturated vector");

endmodule

`default_nettype wire

>>> hdl/swerve_inverse_kinematics.sv
// Swerve inverse kinematics: one item at a time, the next accepted only after the result is valid.
// Front end: 16-step serial products, a 16-step serial scale product and a 27-step
// restoring divider; then four wheels in turn through sik_wheel (normalizing shift up
// to 29 steps, 24 CORDIC steps, 28 squaring steps, 29 root steps).
// Synchronous active-low reset clears control, registers to their defaults, held angle 0.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none

module swerve_inverse_kinematics
  import sik_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,    // vel_x, vel_y, yaw_rate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // speed/angle front_left, front_right, back_left, back_right
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL1  = 11'b00000000010,
    S_MUL2  = 11'b00000000100,
    S_PICK  = 11'b00000001000,
    S_SMUL  = 11'b00000010000,
    S_DINIT = 11'b00000100000,
    S_SDIV  = 11'b00001000000,
    S_VEC   = 11'b00010000000,
    S_ISSUE = 11'b00100000000,
    S_WAIT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } st_t;

  st_t                state_r;
  logic [14:0]        max_rpm_r, half_track_r;
  logic [15:0]        speed_scale_r;
  logic               sx_r, sy_r, st_r, vy_zero_r, w_zero_r;
  logic [15:0]        avx_r, avy_r, aw_r;
  logic [30:0]        xm_r, ym_r, t1_r;
  logic [46:0]        tacc_r;
  logic [34:0]        tm_r;
  logic [4:0]         cnt_r;
  logic               scaled_r, sel_t_r;
  logic [30:0]        su_r;
  logic [34:0]        sv_r;
  logic [35:0]        den_r;
  logic [45:0]        pu_r;
  logic [49:0]        pv_r;
  logic [35:0]        remu_r, remv_r;
  logic [26:0]        lowu_r, lowv_r, qu_r, qv_r;
  logic signed [37:0] a_r, b_r, c_r, d_r;
  logic [1:0]         idx_r;
  sik_res_t           res_r [4];
  logic               out_tvalid_r;
  logic [127:0]       out_tdata_r;

  logic               cfg_wr;
  logic [15:0]        ht16, mx16;
  logic [3:0]         bsel;
  logic [47:0]        trnd_c;
  logic [31:0]        sum_xy_c;
  logic [35:0]        sum_xt_c;
  logic [26:0]        lim_c;
  logic [36:0]        tu_c, tv_c;
  logic               geu_c, gev_c;
  logic [30:0]        xe_c, ye_c;
  logic [34:0]        te_c;
  logic signed [37:0] xs_c, ys_c, ts_c;
  sik_vec_t           wh_vec;
  logic               wh_start, wh_done;
  sik_res_t           wh_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign wh_start   = (state_r == S_ISSUE);

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MAX_RPM:     cfg_prdata = {17'd0, max_rpm_r};
      REG_SPEED_SCALE: cfg_prdata = {16'd0, speed_scale_r};
      REG_HALF_TRACK:  cfg_prdata = {17'd0, half_track_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    ht16     = {1'b0, half_track_r};
    mx16     = {1'b0, max_rpm_r};
    bsel     = ~cnt_r[3:0];
    trnd_c   = {1'b0, tacc_r} + 48'd2048;
    sum_xy_c = {1'b0, xm_r} + {1'b0, ym_r};
    sum_xt_c = {5'd0, xm_r} + {1'b0, trnd_c[46:12]};
    lim_c    = {max_rpm_r, 12'd0};
    tu_c     = {remu_r, lowu_r[26]};
    tv_c     = {remv_r, lowv_r[26]};
    geu_c    = tu_c >= {1'b0, den_r};
    gev_c    = tv_c >= {1'b0, den_r};
    xe_c     = scaled_r ? {4'd0, qu_r} : xm_r;
    ye_c     = (scaled_r && !sel_t_r) ? {4'd0, qv_r} : ym_r;
    te_c     = (scaled_r && sel_t_r) ? {8'd0, qv_r} : tm_r;
    xs_c     = $signed({7'd0, xe_c});
    ys_c     = $signed({7'd0, ye_c});
    ts_c     = $signed({3'd0, te_c});
    if (sx_r) xs_c = -xs_c;
    if (sy_r) ys_c = -ys_c;
    if (st_r) ts_c = -ts_c;
    wh_vec.p = idx_r[0] ? a_r : b_r;
    wh_vec.q = idx_r[1] ? d_r : c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rpm_r     <= 15'd4800;
      speed_scale_r <= 16'd9170;
      half_track_r  <= 15'd1024;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MAX_RPM:     max_rpm_r     <= cfg_pwdata[14:0];
        REG_SPEED_SCALE: speed_scale_r <= cfg_pwdata[15:0];
        REG_HALF_TRACK:  half_track_r  <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cnt_r        <= 5'd0;
      idx_r        <= 2'd0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sx_r      <= in_tdata[15];
            sy_r      <= in_tdata[31];
            st_r      <= in_tdata[47];
            avx_r     <= in_tdata[15] ? 16'(-in_tdata[15:0]) : in_tdata[15:0];
            avy_r     <= in_tdata[31] ? 16'(-in_tdata[31:16]) : in_tdata[31:16];
            aw_r      <= in_tdata[47] ? 16'(-in_tdata[47:32]) : in_tdata[47:32];
            vy_zero_r <= (in_tdata[31:16] == 16'd0);
            w_zero_r  <= (in_tdata[47:32] == 16'd0);
            xm_r      <= 31'd0;
            ym_r      <= 31'd0;
            t1_r      <= 31'd0;
            cnt_r     <= 5'd0;
            state_r   <= S_MUL1;
          end
        end
        S_MUL1: begin
          xm_r <= {xm_r[29:0], 1'b0} + (speed_scale_r[bsel] ? {15'd0, avx_r} : 31'd0);
          ym_r <= {ym_r[29:0], 1'b0} + (speed_scale_r[bsel] ? {15'd0, avy_r} : 31'd0);
          t1_r <= {t1_r[29:0], 1'b0} + (ht16[bsel] ? {15'd0, aw_r} : 31'd0);
          if (cnt_r == 5'd15) begin
            cnt_r   <= 5'd0;
            tacc_r  <= 47'd0;
            state_r <= S_MUL2;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MUL2: begin
          tacc_r <= {tacc_r[45:0], 1'b0} + (speed_scale_r[bsel] ? {16'd0, t1_r} : 47'd0);
          if (cnt_r == 5'd15) begin
            cnt_r   <= 5'd0;
            state_r <= S_PICK;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_PICK: begin
          scaled_r <= 1'b0;
          pu_r     <= 46'd0;
          pv_r     <= 50'd0;
          if (w_zero_r && sum_xy_c >= {5'd0, lim_c}) begin
            su_r    <= xm_r;
            sv_r    <= {4'd0, ym_r};
            den_r   <= {4'd0, sum_xy_c};
            sel_t_r <= 1'b0;
            state_r <= (sum_xy_c != 32'd0) ? S_SMUL : S_VEC;
          end else if (sum_xt_c >= {9'd0, lim_c} && vy_zero_r && sum_xt_c != 36'd0) begin
            su_r    <= xm_r;
            sv_r    <= trnd_c[46:12];
            den_r   <= sum_xt_c;
            sel_t_r <= 1'b1;
            state_r <= S_SMUL;
          end else begin
            state_r <= S_VEC;
          end
          tm_r <= trnd_c[46:12];
        end
        S_SMUL: begin
          pu_r <= {pu_r[44:0], 1'b0} + (mx16[bsel] ? {15'd0, su_r} : 46'd0);
          pv_r <= {pv_r[48:0], 1'b0} + (mx16[bsel] ? {15'd0, sv_r} : 50'd0);
          if (cnt_r == 5'd15) begin
            cnt_r   <= 5'd0;
            state_r <= S_DINIT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_DINIT: begin
          remu_r  <= {5'd0, pu_r[45:15]};
          lowu_r  <= {pu_r[14:0], 12'd0};
          remv_r  <= {1'b0, pv_r[49:15]};
          lowv_r  <= {pv_r[14:0], 12'd0};
          state_r <= S_SDIV;
        end
        S_SDIV: begin
          remu_r <= geu_c ? 36'(tu_c - {1'b0, den_r}) : tu_c[35:0];
          remv_r <= gev_c ? 36'(tv_c - {1'b0, den_r}) : tv_c[35:0];
          qu_r   <= {qu_r[25:0], geu_c};
          qv_r   <= {qv_r[25:0], gev_c};
          lowu_r <= {lowu_r[25:0], 1'b0};
          lowv_r <= {lowv_r[25:0], 1'b0};
          if (cnt_r == 5'd26) begin
            cnt_r    <= 5'd0;
            scaled_r <= 1'b1;
            state_r  <= S_VEC;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_VEC: begin
          a_r     <= xs_c + ts_c;
          b_r     <= xs_c - ts_c;
          c_r     <= ys_c + ts_c;
          d_r     <= ys_c - ts_c;
          idx_r   <= 2'd0;
          state_r <= S_ISSUE;
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (wh_done) begin
            res_r[idx_r] <= wh_res;
            if (idx_r == 2'd3) begin
              state_r <= S_OUT;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {res_r[3], res_r[2], res_r[1], res_r[0]};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  sik_wheel u_wheel (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (wh_start),
    .vec     (wh_vec),
    .max_rpm (max_rpm_r),
    .done    (wh_done),
    .res     (wh_res)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL1)) else $error("accept did not start");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    wh_done |-> (state_r == S_WAIT)) else $error("wheel result outside wait");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SDIV) |-> (remu_r < den_r && remv_r < den_r))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire
